/* rtl/rar_pkg.sv */
// Shared types and operation codes for the rational arithmetic reduction block.
package rar_pkg;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	// Handshake status of an iterative arithmetic unit toward the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

endpackage

/* rtl/rar_gcd.sv */
// Iterative binary greatest-common-divisor unit, one shift or subtract per cycle.
module rar_gcd #(
	parameter int NW = 33
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NW-1:0]         x_in,
	input  logic [NW-1:0]         y_in,
	output rar_pkg::unit_status_t status,
	output logic [NW-1:0]         g
);

	localparam int KW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] x_q;
	logic [NW-1:0] y_q;
	logic [KW-1:0] k_q;
	logic [NW-1:0] g_q;
	logic          x_ge_y;
	logic [NW-1:0] diff;

	// The single compare and subtract shared by every odd-odd step.
	assign x_ge_y = (x_q >= y_q);
	assign diff   = x_ge_y ? (x_q - y_q) : (y_q - x_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
			end else if (busy_q && ((x_q == '0) || (y_q == '0))) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			x_q <= x_in;
			y_q <= y_in;
			k_q <= '0;
		end else if (busy_q) begin
			priority if (x_q == '0) begin
				g_q <= y_q << k_q;
			end else if (y_q == '0) begin
				g_q <= x_q << k_q;
			end else if (!x_q[0] && !y_q[0]) begin
				// Common factor of two: strip it from both and count it.
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_ge_y) begin
				x_q <= diff;
			end else begin
				y_q <= diff;
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign g           = g_q;

endmodule

/* rtl/rar_div.sv */
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module rar_div #(
	parameter int NW = 33
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NW-1:0]         dividend,
	input  logic [NW-1:0]         divisor,
	output rar_pkg::unit_status_t status,
	output logic [NW-1:0]         quotient
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] r_q;
	logic [NW-1:0] q_q;
	logic [NW-1:0] d_q;
	logic [NW:0]   shifted;
	logic [NW:0]   diff;
	logic          take;

	assign shifted = {r_q, q_q[NW-1]};
	assign take    = (shifted >= {1'b0, d_q});
	assign diff    = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			r_q <= '0;
			q_q <= dividend;
			d_q <= divisor;
		end else if (busy_q) begin
			// The remainder stays below the divisor, so NW bits hold it.
			r_q <= take ? diff[NW-1:0] : shifted[NW-1:0];
			q_q <= {q_q[NW-2:0], take};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = q_q;

endmodule

/* rtl/rational_arith_reduce_core.sv */
// Top level: fraction arithmetic with cross products and gcd reduction.
//
// The slave stream carries one operation per transaction: the command and
// two signed fractions. The master stream returns the reduced numerator
// and denominator, with tuser set when the denominator came out zero; the
// terms are then the unreduced cross products.
// One shared signed multiplier forms the cross products. A binary gcd unit
// then takes one shift or one subtract per cycle, and one bit-serial divider
// divides numerator and denominator in turn by the gcd. A zero denominator
// skips the gcd and the divisions. The block takes one transaction at a
// time: s_tready is high only while the sequencer is free.
// The result sits in an output register, so the next transaction is taken
// while the receiver stalls; a finished result waits until that register
// empties. Reset clears the sequencer and the output valid; nothing else
// is kept from one transaction to the next.
module rational_arith_reduce_core #(
	parameter int OPERAND_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// cmd, a_num, a_den, b_num, b_den from bit 0 up, zero padded.
	input  logic [((2 + 4 * OPERAND_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// result_num, result_den from bit 0 up, zero padded.
	output logic [((4 * OPERAND_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
	// zero_denominator.
	output logic m_tuser
);

	localparam int W       = OPERAND_BITS;
	localparam int NW      = 2 * W + 1;
	localparam int DW      = 2 * W;
	localparam int OUT_PAD = ((4 * W + 1 + 7) / 8) * 8;
	localparam int AN_LO   = 2;
	localparam int AD_LO   = 2 + W;
	localparam int BN_LO   = 2 + 2 * W;
	localparam int BD_LO   = 2 + 3 * W;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_MDEN  = 10'b00_0000_0010,
		ST_MNUM1 = 10'b00_0000_0100,
		ST_MNUM2 = 10'b00_0000_1000,
		ST_MSUM  = 10'b00_0001_0000,
		ST_CHK   = 10'b00_0010_0000,
		ST_GCD   = 10'b00_0100_0000,
		ST_DIVN  = 10'b00_1000_0000,
		ST_DIVD  = 10'b01_0000_0000,
		ST_DONE  = 10'b10_0000_0000
	} state_t;

	state_t               state_q;
	state_t               state_d;
	rar_pkg::cmd_t        cmd_q;
	logic signed [W-1:0]  an_q;
	logic signed [W-1:0]  ad_q;
	logic signed [W-1:0]  bn_q;
	logic signed [W-1:0]  bd_q;
	logic signed [W-1:0]  mul_x;
	logic signed [W-1:0]  mul_y;
	logic signed [DW-1:0] prod_w;
	logic signed [DW-1:0] prod_q;
	logic signed [NW-1:0] prod_ext;
	logic signed [NW-1:0] num_q;
	logic signed [DW-1:0] den_q;
	logic                 zden_q;
	logic [NW-1:0]        mag_num;
	logic [NW-1:0]        mag_den;
	logic [DW-1:0]        den_abs;
	logic                 gcd_start;
	logic                 div_start;
	logic [NW-1:0]        div_dividend;
	logic [NW-1:0]        gcd_g;
	logic [NW-1:0]        div_q;
	rar_pkg::unit_status_t gcd_st;
	rar_pkg::unit_status_t div_st;
	logic                 out_load;
	logic                 m_tvalid_q;
	logic [NW-1:0]        num_out_q;
	logic [DW-1:0]        den_out_q;
	logic                 zden_out_q;

	// Shared multiplier: the denominator product first, then the numerator terms.
	always_comb begin
		mul_x = '0;
		mul_y = '0;
		unique case (state_q)
			ST_MDEN: begin
				mul_x = ad_q;
				mul_y = (cmd_q == rar_pkg::CMD_DIV) ? bn_q : bd_q;
			end
			ST_MNUM1: begin
				mul_x = an_q;
				mul_y = (cmd_q == rar_pkg::CMD_MUL) ? bn_q : bd_q;
			end
			ST_MNUM2: begin
				mul_x = bn_q;
				mul_y = ad_q;
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	assign prod_w   = DW'(mul_x) * DW'(mul_y);
	assign prod_ext = NW'(prod_q);

	always_ff @(posedge clk) begin
		prod_q <= prod_w;
	end

	assign mag_num = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
	assign den_abs = den_q[DW-1] ? DW'(-den_q) : DW'(den_q);
	assign mag_den = NW'(den_abs);

	assign gcd_start    = (state_q == ST_CHK) && (den_q != '0);
	assign div_start    = ((state_q == ST_GCD) && gcd_st.done) ||
	                      ((state_q == ST_DIVN) && div_st.done);
	assign div_dividend = (state_q == ST_GCD) ? mag_num : mag_den;
	assign out_load     = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	rar_gcd #(
		.NW(NW)
	) u_gcd (
		.clk   (clk),
		.arst_n(arst_n),
		.start (gcd_start),
		.x_in  (mag_num),
		.y_in  (mag_den),
		.status(gcd_st),
		.g     (gcd_g)
	);

	rar_div #(
		.NW(NW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (gcd_g),
		.status  (div_st),
		.quotient(div_q)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_MDEN;
			ST_MDEN:  state_d = ST_MNUM1;
			ST_MNUM1: state_d = ST_MNUM2;
			ST_MNUM2: begin
				if ((cmd_q == rar_pkg::CMD_ADD) || (cmd_q == rar_pkg::CMD_SUB)) begin
					state_d = ST_MSUM;
				end else begin
					state_d = ST_CHK;
				end
			end
			ST_MSUM:  state_d = ST_CHK;
			ST_CHK:   state_d = (den_q == '0) ? ST_DONE : ST_GCD;
			ST_GCD:   if (gcd_st.done) state_d = ST_DIVN;
			ST_DIVN:  if (div_st.done) state_d = ST_DIVD;
			ST_DIVD:  if (div_st.done) state_d = ST_DONE;
			ST_DONE:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && s_tvalid) begin
			cmd_q <= rar_pkg::cmd_t'(s_tdata[1:0]);
			an_q  <= s_tdata[AN_LO +: W];
			ad_q  <= s_tdata[AD_LO +: W];
			bn_q  <= s_tdata[BN_LO +: W];
			bd_q  <= s_tdata[BD_LO +: W];
		end
		if (state_q == ST_MNUM1) begin
			den_q <= prod_q;
		end
		if (state_q == ST_MNUM2) begin
			num_q <= prod_ext;
		end
		if (state_q == ST_MSUM) begin
			num_q <= (cmd_q == rar_pkg::CMD_SUB) ? (num_q - prod_ext) : (num_q + prod_ext);
		end
		if (state_q == ST_CHK) begin
			zden_q <= (den_q == '0);
		end
		// Both divisions are exact, so the sign is put back on the magnitude.
		if ((state_q == ST_DIVN) && div_st.done) begin
			num_q <= num_q[NW-1] ? -$signed(div_q) : $signed(div_q);
		end
		if ((state_q == ST_DIVD) && div_st.done) begin
			den_q <= den_q[DW-1] ? -$signed(div_q[DW-1:0]) : $signed(div_q[DW-1:0]);
		end
		if (out_load) begin
			num_out_q  <= num_q;
			den_out_q  <= den_q;
			zden_out_q <= zden_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_PAD'({den_out_q, num_out_q});
	assign m_tuser  = zden_out_q;

	a_flag_matches_den: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (zden_out_q == (den_out_q == '0)))
		else $error("zero_denominator flag disagrees with the result denominator");

	a_gcd_done_in_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_st.done |-> (state_q == ST_GCD))
		else $error("gcd unit finished outside the gcd phase");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> ((state_q == ST_DIVN) || (state_q == ST_DIVD)))
		else $error("divider finished outside a division phase");

endmodule

/* tb/rational_arith_reduce_core_tb.sv */
// Testbench for the rational arithmetic reduction core: directed table plus random stream.
`timescale 1ns / 1ps

module rational_arith_reduce_core_tb;

	localparam int OB = 16;
	localparam int SW = ((2 + 4 * OB + 7) / 8) * 8;
	localparam int MW = ((4 * OB + 1 + 7) / 8) * 8;
	localparam int NW = 2 * OB + 1;
	localparam int DW = 2 * OB;
	localparam int N_RANDOM = 2000;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = 250;

	typedef struct packed {
		logic signed [NW-1:0] num;
		logic signed [DW-1:0] den;
		logic                 zden;
	} fraction_t;

	typedef struct {
		logic [SW-1:0] word;
		bit            known;
		fraction_t     exp;
	} stim_row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [SW-1:0] s_tdata = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [MW-1:0] m_tdata;
	logic          m_tuser;

	// Typed expectation that travels alongside the transaction being offered.
	bit            typed_valid = 1'b0;
	fraction_t     typed_exp = '0;

	fraction_t     expected_fractions[$];
	stim_row_t     dir_rows[$];
	int            mismatches = 0;
	int            n_sent = 0;
	int            n_checked = 0;
	int            n_zero_den = 0;
	int            op_count[4] = '{0, 0, 0, 0};
	int            idle_cycles = 0;

	rational_arith_reduce_core #(
		.OPERAND_BITS(OB)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint unsigned magnitude_gcd(longint unsigned x, longint unsigned y);
		int unsigned    shift;
		longint unsigned t;
		shift = 0;
		if (x == 0)
			return y;
		if (y == 0)
			return x;
		while (((x | y) & 64'd1) == 0) begin
			x >>= 1;
			y >>= 1;
			shift++;
		end
		while ((x & 64'd1) == 0)
			x >>= 1;
		while (y != 0) begin
			while ((y & 64'd1) == 0)
				y >>= 1;
			if (x > y) begin
				t = x;
				x = y;
				y = t;
			end
			y -= x;
		end
		return x << shift;
	endfunction

	function automatic fraction_t reduce_fraction_op(logic [SW-1:0] w);
		rar_pkg::cmd_t   op;
		longint          an, ad, bn, bd, num, den;
		longint unsigned g;
		fraction_t       r;
		op = rar_pkg::cmd_t'(w[1:0]);
		an = longint'($signed(w[2 +: OB]));
		ad = longint'($signed(w[2 + OB +: OB]));
		bn = longint'($signed(w[2 + 2 * OB +: OB]));
		bd = longint'($signed(w[2 + 3 * OB +: OB]));
		case (op)
			rar_pkg::CMD_ADD: begin
				num = an * bd + bn * ad;
				den = ad * bd;
			end
			rar_pkg::CMD_SUB: begin
				num = an * bd - bn * ad;
				den = ad * bd;
			end
			rar_pkg::CMD_MUL: begin
				num = an * bn;
				den = ad * bd;
			end
			default: begin
				num = an * bd;
				den = ad * bn;
			end
		endcase
		r.zden = (den == 0);
		// With a zero denominator the cross products are returned unreduced.
		if (!r.zden) begin
			g = magnitude_gcd(num < 0 ? -num : num, den < 0 ? -den : den);
			num = num / longint'(g);
			den = den / longint'(g);
		end
		r.num = num[NW-1:0];
		r.den = den[DW-1:0];
		return r;
	endfunction

	function automatic logic [SW-1:0] pack_op(rar_pkg::cmd_t op, logic [OB-1:0] an,
			logic [OB-1:0] ad, logic [OB-1:0] bn, logic [OB-1:0] bd);
		logic [SW-1:0] w;
		w = '0;
		w[1:0] = op;
		w[2 +: OB] = an;
		w[2 + OB +: OB] = ad;
		w[2 + 2 * OB +: OB] = bn;
		w[2 + 3 * OB +: OB] = bd;
		return w;
	endfunction

	task automatic add_row(rar_pkg::cmd_t op, longint an, longint ad, longint bn, longint bd,
			bit known, longint num, longint den, bit zden);
		stim_row_t row;
		row.word = pack_op(op, an[OB-1:0], ad[OB-1:0], bn[OB-1:0], bd[OB-1:0]);
		row.known = known;
		row.exp.num = num[NW-1:0];
		row.exp.den = den[DW-1:0];
		row.exp.zden = zden;
		dir_rows.push_back(row);
	endtask

	function automatic logic [OB-1:0] rand_operand();
		logic [OB-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = OB'($urandom);
			4, 5, 6: v = OB'($urandom_range(0, 16) - 8);
			7: begin
				case ($urandom_range(0, 4))
					0: v = {1'b1, {(OB - 1){1'b0}}};
					1: v = {1'b0, {(OB - 1){1'b1}}};
					2: v = '1;
					3: v = {{(OB - 1){1'b0}}, 1'b1};
					default: v = '0;
				endcase
			end
			8: v = '0;
			default: begin
				// Small factor from 1 to 7 times a power of two gives long gcd runs.
				v = OB'($urandom_range(1, 7) << $urandom_range(0, OB - 4));
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic note_mismatch(string what, fraction_t want, fraction_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected num=%0d den=%0d zden=%0b, got num=%0d den=%0d zden=%0b",
				$realtime, what, want.num, want.den, want.zden, got.num, got.den, got.zden);
	endtask

	task automatic send_op(logic [SW-1:0] w, bit known, fraction_t exp);
		typed_valid <= known;
		typed_exp <= exp;
		s_tdata <= w;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic pause_sender(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_fractions.size() != 0);
	endtask

	// Scoreboard: predict on each accepted operation, check each accepted result.
	always @(posedge clk) begin
		fraction_t want, got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = typed_valid ? typed_exp : reduce_fraction_op(s_tdata);
				expected_fractions.push_back(want);
				n_sent++;
				op_count[s_tdata[1:0]]++;
			end
			if (m_tvalid && m_tready) begin
				got.num = m_tdata[NW-1:0];
				got.den = m_tdata[NW +: DW];
				got.zden = m_tuser;
				n_checked++;
				if (got.zden === 1'b1)
					n_zero_den++;
				if (expected_fractions.size() == 0) begin
					note_mismatch("result with nothing pending", got, got);
				end else begin
					want = expected_fractions.pop_front();
					if (got.num !== want.num || got.den !== want.den || got.zden !== want.zden)
						note_mismatch("result mismatch", want, got);
				end
			end
		end
	end

	// Receiver backpressure: the stall pattern switches at random among four modes.
	logic [1:0] rx_mode = 2'd0;
	int         rx_cycle = 0;
	int         rx_stall = 0;
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 300 == 299)
			rx_mode <= 2'($urandom_range(0, 3));
		case (rx_mode)
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= 1'($urandom_range(0, 1));
			2'd2: m_tready <= (rx_cycle % 7) < 3;
			default: begin
				if (rx_stall > 0) begin
					rx_stall <= rx_stall - 1;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
					if ($urandom_range(0, 9) == 0)
						rx_stall <= $urandom_range(1, 24);
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int burst_left;
		int gap;
		add_row(rar_pkg::CMD_ADD, 1, 2, 1, 3, 1, 5, 6, 0);
		add_row(rar_pkg::CMD_SUB, 1, 2, 1, 3, 1, 1, 6, 0);
		add_row(rar_pkg::CMD_MUL, 2, 3, 3, 4, 1, 1, 2, 0);
		add_row(rar_pkg::CMD_DIV, 1, 2, 3, 4, 1, 2, 3, 0);
		// Zero numerator reduces to 0 over the sign of the denominator.
		add_row(rar_pkg::CMD_ADD, 0, 5, 0, -3, 1, 0, -1, 0);
		add_row(rar_pkg::CMD_MUL, 0, 7, 4, 9, 1, 0, 1, 0);
		add_row(rar_pkg::CMD_SUB, -1, -2, 1, 2, 1, 0, -1, 0);
		add_row(rar_pkg::CMD_SUB, 32767, 32767, -32768, -32768, 1, 0, -1, 0);
		// Zero denominator keeps the raw cross products.
		add_row(rar_pkg::CMD_ADD, 3, 0, 5, 7, 1, 21, 0, 1);
		add_row(rar_pkg::CMD_MUL, 0, 0, 0, 0, 1, 0, 0, 1);
		add_row(rar_pkg::CMD_DIV, 1, 2, 0, 5, 1, 5, 0, 1);
		add_row(rar_pkg::CMD_DIV, -32768, -32768, 0, -32768, 1, 64'sd1073741824, 0, 1);
		// Signs stay where the arithmetic puts them.
		add_row(rar_pkg::CMD_MUL, 1, -2, 1, 3, 1, 1, -6, 0);
		add_row(rar_pkg::CMD_MUL, -1, -1, -1, -1, 1, 1, 1, 0);
		add_row(rar_pkg::CMD_MUL, -32768, -32768, -32768, -32768, 1, 1, 1, 0);
		add_row(rar_pkg::CMD_ADD, -32768, 1, -32768, 1, 1, -65536, 1, 0);
		add_row(rar_pkg::CMD_MUL, 32767, 1, 32767, 1, 1, 64'sd1073676289, 1, 0);
		add_row(rar_pkg::CMD_ADD, 6, 4, 10, 8, 1, 11, 4, 0);
		add_row(rar_pkg::CMD_DIV, -5, 3, 10, -6, 1, 1, 1, 0);
		add_row(rar_pkg::CMD_ADD, -32768, -32767, -32768, -32767, 0, 0, 0, 0);
		add_row(rar_pkg::CMD_SUB, 32767, -32768, -32768, 32767, 0, 0, 0, 0);
		add_row(rar_pkg::CMD_DIV, 32767, -32768, -32768, 32767, 0, 0, 0, 0);
		add_row(rar_pkg::CMD_ADD, 12345, -32768, -1, 3, 0, 0, 0, 0);
		add_row(rar_pkg::CMD_MUL, -32768, 32767, 32767, -32768, 0, 0, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_op(dir_rows[i].word, dir_rows[i].known, dir_rows[i].exp);
		wait_for_drain();

		burst_left = 0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2)
				wait_for_drain();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
				if (gap > 0)
					pause_sender(gap);
			end
			send_op(pack_op(rar_pkg::cmd_t'($urandom_range(0, 3)), rand_operand(),
				rand_operand(), rand_operand(), rand_operand()), 1'b0, '0);
			burst_left--;
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_fractions.size() != 0)
			note_mismatch("expectation left over", expected_fractions[0], '0);

		$display("Ran %0d fraction operations: %0d add, %0d sub, %0d mul, %0d div.",
			n_sent, op_count[rar_pkg::CMD_ADD], op_count[rar_pkg::CMD_SUB],
			op_count[rar_pkg::CMD_MUL], op_count[rar_pkg::CMD_DIV]);
		$display("Checked %0d results, %0d with a zero denominator, %0d mismatches.",
			n_checked, n_zero_den, mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
